FILE: hw/rtl/blop_pkg.sv
// Package for the binomial lattice pricer: payload types, register codes and helpers.
`default_nettype none
package blop_pkg;

    localparam int DEF_MAX_STEPS = 256;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_OVER_UP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_UP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PROB     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STEPS   = 3'd5;

    typedef struct packed {
        logic [31:0] spot;
        logic [31:0] strike;
        logic        is_call;
        logic        is_american;
    } t_in;

    typedef struct packed {
        logic [31:0] option_price;
        logic        overflow;
    } t_out;

    // broadcast from the sequencer to every lattice cell
    typedef struct packed {
        logic        shift;
        logic        ph_a;
        logic        ph_b;
        logic        ph_c;
        logic [31:0] strike;
        logic        is_call;
        logic        is_american;
        logic [30:0] prob_up;
        logic [30:0] prob_dn;
        logic [30:0] discount;
        logic [31:0] inverse_up;
    } t_cell_ctl;

    // Q2.30 product scaling with saturation: {overflow, value}
    function automatic logic [32:0] sat_q30(input logic [63:0] prod);
        logic [33:0] sh;
        sh = prod[63:30];
        if (|sh[33:32]) begin
            return {1'b1, 32'hFFFF_FFFF};
        end
        return {1'b0, sh[31:0]};
    endfunction

    function automatic logic [31:0] payoff(input logic [31:0] price,
                                           input logic [31:0] strike,
                                           input logic        is_call);
        if (is_call) begin
            return (price > strike) ? price - strike : 32'd0;
        end
        return (strike > price) ? strike - price : 32'd0;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/blop_cell.sv
// One lattice cell: holds a node value and node price, does one backward step in three phases.
`default_nettype none
module blop_cell
    import blop_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic        i_active,
    input  wire logic [31:0] i_up_value,
    input  wire logic [31:0] i_up_price,
    output logic [31:0]      o_value,
    output logic [31:0]      o_price,
    output logic             o_sat
);

    logic [31:0] r_value;
    logic [31:0] r_price;
    logic [61:0] r_mix;
    logic [63:0] r_px_prod;
    logic [62:0] r_disc_prod;
    logic [31:0] r_ex_price;
    logic        r_ex_sat;

    logic [32:0] disc_sat;
    logic [31:0] ex_val;
    logic [31:0] new_val;

    always_comb begin
        disc_sat = sat_q30({1'b0, r_disc_prod});
        ex_val   = payoff(r_ex_price, i_ctl.strike, i_ctl.is_call);
        new_val  = (i_ctl.is_american && (ex_val > disc_sat[31:0])) ? ex_val : disc_sat[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_up_value;
            r_price <= i_up_price;
        end else if (i_ctl.ph_a) begin
            // p and 1-p sum to one, so the weighted pair stays below 2^62
            r_mix <= 62'(({32'd0, i_ctl.prob_up} * {32'd0, r_value})
                        + ({32'd0, i_ctl.prob_dn} * {32'd0, i_up_value}));
            r_px_prod <= {32'd0, r_price} * {32'd0, i_ctl.inverse_up};
        end else if (i_ctl.ph_b) begin
            r_disc_prod <= {31'd0, r_mix[61:30]} * {32'd0, i_ctl.discount};
            {r_ex_sat, r_ex_price} <= sat_q30(r_px_prod);
        end else if (i_ctl.ph_c && i_active) begin
            r_value <= new_val;
            if (i_ctl.is_american) begin
                r_price <= r_ex_price;
            end
        end
    end

    assign o_value = r_value;
    assign o_price = r_price;
    assign o_sat   = i_ctl.ph_c && i_active
                     && (disc_sat[32] || (i_ctl.is_american && r_ex_sat));

endmodule
`default_nettype wire

FILE: hw/rtl/binomial_lattice_option_pricer_core.sv
// Top level of the binomial lattice pricer: registers, sequencer and the chain of cells.
// One item prices one option with N = min(num_steps, MAX_STEPS) steps. It forms spot*u^N
// on the sequencer's single multiplier, builds and shifts the leaves into the cell chain,
// runs backward induction (every cell does one step in three phases), shifts node 0 down to
// the first cell, shows the result and returns to idle before the next start is taken.
// The result appears for one cycle with o_done; it cannot be held off.
// Write configuration only while o_busy is low.
`default_nettype none
module binomial_lattice_option_pricer_core
    import blop_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire t_in                  i_in,
    output logic                      o_busy,
    output logic                      o_done,
    output t_out                      o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    localparam int NW    = $clog2(MAX_STEPS + 1);
    localparam int CELLS = MAX_STEPS + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_POW_MUL  = 4'd1;
    localparam logic [3:0] ST_POW_SAT  = 4'd2;
    localparam logic [3:0] ST_PUSH     = 4'd3;
    localparam logic [3:0] ST_LEAF_MUL = 4'd4;
    localparam logic [3:0] ST_LEAF_SAT = 4'd5;
    localparam logic [3:0] ST_STEP_A   = 4'd6;
    localparam logic [3:0] ST_STEP_B   = 4'd7;
    localparam logic [3:0] ST_STEP_C   = 4'd8;
    localparam logic [3:0] ST_DRAIN    = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [31:0] r_up_factor;
    logic [31:0] r_down_over_up;
    logic [31:0] r_inverse_up;
    logic [30:0] r_up_prob;
    logic [30:0] r_discount;
    logic [8:0]  r_num_steps;

    logic [3:0]    r_state;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_base;
    logic [NW-1:0] r_lim;
    logic [NW-1:0] r_cnt;
    logic [31:0]   r_s;
    logic [63:0]   r_prod;
    logic          r_ovf;
    logic [31:0]   r_strike;
    logic          r_call;
    logic          r_american;
    logic [30:0]   r_p;

    logic [NW-1:0] n_clamped;
    logic [30:0]   p_clamped;
    logic [32:0]   s_sat;
    t_cell_ctl     ctl;

    logic [31:0]    cell_val [CELLS];
    logic [31:0]    cell_prc [CELLS];
    logic [CELLS-1:0] cell_sat;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor    <= 32'h4000_0000;
            r_down_over_up <= 32'h4000_0000;
            r_inverse_up   <= 32'h4000_0000;
            r_up_prob      <= 31'h2000_0000;
            r_discount     <= 31'h4000_0000;
            r_num_steps    <= 9'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_UP_FACTOR:    r_up_factor    <= i_cfg_data;
                CFG_DOWN_OVER_UP: r_down_over_up <= i_cfg_data;
                CFG_INVERSE_UP:   r_inverse_up   <= i_cfg_data;
                CFG_UP_PROB:      r_up_prob      <= i_cfg_data[30:0];
                CFG_DISCOUNT:     r_discount     <= i_cfg_data[30:0];
                CFG_NUM_STEPS:    r_num_steps    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_clamped = (32'(r_num_steps) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(r_num_steps);
        p_clamped = (r_up_prob > ONE_Q30) ? ONE_Q30 : r_up_prob;
        s_sat     = sat_q30(r_prod);

        ctl.shift       = (r_state == ST_PUSH) || (r_state == ST_DRAIN);
        ctl.ph_a        = (r_state == ST_STEP_A);
        ctl.ph_b        = (r_state == ST_STEP_B);
        ctl.ph_c        = (r_state == ST_STEP_C);
        ctl.strike      = r_strike;
        ctl.is_call     = r_call;
        ctl.is_american = r_american;
        ctl.prob_up     = r_p;
        ctl.prob_dn     = ONE_Q30 - r_p;
        ctl.discount    = r_discount;
        ctl.inverse_up  = r_inverse_up;
    end

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            logic [31:0] up_v;
            logic [31:0] up_p;
            if (g == CELLS - 1) begin : g_top
                // new leaves enter at the top and the chain shifts down
                assign up_v = payoff(r_s, r_strike, r_call);
                assign up_p = r_s;
            end else begin : g_mid
                assign up_v = cell_val[g+1];
                assign up_p = cell_prc[g+1];
            end
            blop_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_active   ((NW'(g) >= r_base) && (NW'(g) < r_lim)),
                .i_up_value (up_v),
                .i_up_price (up_p),
                .o_value    (cell_val[g]),
                .o_price    (cell_prc[g]),
                .o_sat      (cell_sat[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            if (|cell_sat) begin
                r_ovf <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_s        <= i_in.spot;
                        r_strike   <= i_in.strike;
                        r_call     <= i_in.is_call;
                        r_american <= i_in.is_american;
                        r_p        <= p_clamped;
                        r_n        <= n_clamped;
                        r_base     <= NW'(MAX_STEPS) - n_clamped;
                        r_lim      <= NW'(MAX_STEPS);
                        r_cnt      <= '0;
                        r_ovf      <= 1'b0;
                        r_state    <= (n_clamped == '0) ? ST_PUSH : ST_POW_MUL;
                    end
                end
                ST_POW_MUL: begin
                    r_prod  <= {32'd0, r_s} * {32'd0, r_up_factor};
                    r_state <= ST_POW_SAT;
                end
                ST_POW_SAT: begin
                    r_s <= s_sat[31:0];
                    if (s_sat[32]) r_ovf <= 1'b1;
                    if (r_cnt == r_n - 1'b1) begin
                        r_cnt   <= '0;
                        r_state <= ST_PUSH;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_POW_MUL;
                    end
                end
                ST_PUSH: begin
                    if (r_cnt == r_n) begin
                        r_cnt   <= '0;
                        r_state <= (r_n == '0) ? ST_DRAIN : ST_STEP_A;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_LEAF_MUL;
                    end
                end
                ST_LEAF_MUL: begin
                    r_prod  <= {32'd0, r_s} * {32'd0, r_down_over_up};
                    r_state <= ST_LEAF_SAT;
                end
                ST_LEAF_SAT: begin
                    r_s <= s_sat[31:0];
                    if (s_sat[32]) r_ovf <= 1'b1;
                    r_state <= ST_PUSH;
                end
                ST_STEP_A: r_state <= ST_STEP_B;
                ST_STEP_B: r_state <= ST_STEP_C;
                ST_STEP_C: begin
                    r_lim <= r_lim - 1'b1;
                    if (r_lim - 1'b1 == r_base) begin
                        r_cnt   <= '0;
                        r_state <= (r_base == '0) ? ST_DONE : ST_DRAIN;
                    end else begin
                        r_state <= ST_STEP_A;
                    end
                end
                ST_DRAIN: begin
                    // node 0 moves down one cell per cycle until it sits in cell 0
                    if (r_cnt == r_base - 1'b1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done             = (r_state == ST_DONE);
    assign o_out.option_price = cell_val[0];
    assign o_out.overflow     = r_ovf;

endmodule
`default_nettype wire
